[hw/rtl/rmq_pkg.sv]
// Package for the rotation-matrix-to-quaternion block: payload structs,
// branch codes and the side-band record carried through the root pipeline.
// Depends on nothing.
package rmq_pkg;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               degenerate;
  } quat_t;

  // Dominant component codes; they also index the four lanes.
  localparam logic [1:0] DOM_W = 2'd0;
  localparam logic [1:0] DOM_X = 2'd1;
  localparam logic [1:0] DOM_Y = 2'd2;
  localparam logic [1:0] DOM_Z = 2'd3;

  // Width of an off-diagonal sum or difference magnitude.
  localparam int NMW = 17;

  typedef struct packed {
    logic                      vld;
    logic [1:0]                dom;
    logic                      degen;
    logic [3:0]                neg;
    logic [3:0][NMW-1:0]       mag;
  } side_t;

endpackage

[hw/rtl/rmq_if.sv]
// Stream interfaces for the matrix input and quaternion output channels.
// Depends on rmq_pkg for the payload types.
interface rmq_mat_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  mat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmq_quat_if;
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  quat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rotation_matrix_to_quaternion.sv]
// Rotation matrix to unit quaternion, four-branch selection, signed fixed point.
// Depends on rmq_pkg and the stream interfaces in rmq_if.sv.
//
// Usage: a 3x3 matrix arrives as one transfer on the mat channel and leaves
// as one quaternion transfer (w, x, y, z and a degenerate flag) on quat.
// Both channels use valid/ready; a transfer happens when both are high.
// The block is one pipeline: an input register, a branch-select stage, a
// square-root pipeline of RW stages (one result bit per stage), a prepare
// stage, a restoring divider of ND stages (one quotient bit per stage, four
// lanes side by side) and the output register, with RW = (2*FRAC_BITS + 21) / 2
// and ND = FRAC_BITS + 18. A new matrix may be taken in every cycle.
// When the receiver holds ready low while a result waits, the whole pipeline
// freezes and mat.ready falls in the same cycle; nothing is lost or
// repeated. Bubbles inside the pipeline are not squeezed out by such a
// stall, so the input waits for the output transfer even when stages are empty.
// Reset clears every valid bit, so the pipeline comes up empty; the payload
// registers are not reset.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  rmq_mat_if.sink      mat,
  rmq_quat_if.source   quat
);

  // Signed width of the root argument, width of the shifted root operand,
  // root width, numerator width of the division and divisor width.
  localparam int AW  = FRAC_BITS + 20;
  localparam int SW  = 2 * ((AW + FRAC_BITS + 1) / 2);
  localparam int RW  = SW / 2;
  localparam int ND  = NMW + FRAC_BITS + 1;
  localparam int DW  = RW + 1;
  // Clamp limits: +1.0 and -1.0, bounded by the 16-bit signed range.
  localparam int HI  = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam int LOM = (FRAC_BITS >= 15) ? 32768 : (1 << FRAC_BITS);

  // The pipeline moves as a whole whenever the output register can take
  // a new value.
  logic en;
  assign en        = !quat.valid || quat.ready;
  assign mat.ready = en;

  // ---------------------------------------------------------------------
  // Input register.
  logic in_vld;
  mat_t in_mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= mat.valid;
    end
    if (en) begin
      in_mat <= mat.data;
    end
  end

  // ---------------------------------------------------------------------
  // Branch selection: trace, dominant component, root argument and the
  // signed off-diagonal terms for the other three components.
  logic signed [AW-1:0]  e00, e11, e22, trace, arg, one;
  logic signed [NMW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  logic signed [NMW-1:0] nv [4];
  logic [1:0]            sel_dom;
  side_t                 sel_side;
  logic [SW-1:0]         sel_op;

  always_comb begin
    e00   = AW'(in_mat.m00);
    e11   = AW'(in_mat.m11);
    e22   = AW'(in_mat.m22);
    one   = AW'(1) << FRAC_BITS;
    trace = e00 + e11 + e22;
    d21_12 = NMW'(in_mat.m21) - NMW'(in_mat.m12);
    d02_20 = NMW'(in_mat.m02) - NMW'(in_mat.m20);
    d10_01 = NMW'(in_mat.m10) - NMW'(in_mat.m01);
    s01_10 = NMW'(in_mat.m01) + NMW'(in_mat.m10);
    s02_20 = NMW'(in_mat.m02) + NMW'(in_mat.m20);
    s12_21 = NMW'(in_mat.m12) + NMW'(in_mat.m21);
    if (trace > 0) begin
      sel_dom = DOM_W;
      arg = trace + one;
      nv[0] = '0;     nv[1] = d21_12; nv[2] = d02_20; nv[3] = d10_01;
    end else if (in_mat.m00 > in_mat.m11 && in_mat.m00 > in_mat.m22) begin
      sel_dom = DOM_X;
      arg = one + e00 - e11 - e22;
      nv[0] = d21_12; nv[1] = '0;     nv[2] = s01_10; nv[3] = s02_20;
    end else if (in_mat.m11 > in_mat.m22) begin
      sel_dom = DOM_Y;
      arg = one + e11 - e00 - e22;
      nv[0] = d02_20; nv[1] = s01_10; nv[2] = '0;     nv[3] = s12_21;
    end else begin
      sel_dom = DOM_Z;
      arg = one + e22 - e00 - e11;
      nv[0] = d10_01; nv[1] = s02_20; nv[2] = s12_21; nv[3] = '0;
    end
    sel_side.vld   = in_vld;
    sel_side.dom   = sel_dom;
    sel_side.degen = (arg <= 0);
    for (int i = 0; i < 4; i++) begin
      sel_side.neg[i] = nv[i][NMW-1];
      sel_side.mag[i] = nv[i][NMW-1] ? NMW'(-nv[i]) : NMW'(nv[i]);
    end
    // The operand of the root is the argument scaled up by FRAC_BITS.
    sel_op = SW'(unsigned'(arg)) << FRAC_BITS;
  end

  // ---------------------------------------------------------------------
  // Square-root pipeline: stage k brings down two operand bits and decides
  // one root bit by a trial subtraction.
  side_t         sq_side [0:RW];
  logic [RW+1:0] sq_rem  [0:RW];
  logic [RW-1:0] sq_root [0:RW];
  logic [SW-1:0] sq_op   [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side[0].vld <= 1'b0;
    end else if (en) begin
      sq_side[0].vld <= sel_side.vld;
    end
    if (en) begin
      sq_side[0].dom   <= sel_side.dom;
      sq_side[0].degen <= sel_side.degen;
      sq_side[0].neg   <= sel_side.neg;
      sq_side[0].mag   <= sel_side.mag;
      sq_rem[0]        <= '0;
      sq_root[0]       <= '0;
      sq_op[0]         <= sel_op;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+1:0] rem2, trial;
    logic          ge;
    always_comb begin
      rem2  = {sq_rem[k][RW-1:0], sq_op[k][SW-1:SW-2]};
      trial = {sq_root[k], 2'b01};
      ge    = (rem2 >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[k+1].vld <= 1'b0;
      end else if (en) begin
        sq_side[k+1].vld <= sq_side[k].vld;
      end
      if (en) begin
        sq_side[k+1].dom   <= sq_side[k].dom;
        sq_side[k+1].degen <= sq_side[k].degen;
        sq_side[k+1].neg   <= sq_side[k].neg;
        sq_side[k+1].mag   <= sq_side[k].mag;
        sq_rem[k+1]        <= ge ? (rem2 - trial) : rem2;
        sq_root[k+1]       <= {sq_root[k][RW-2:0], ge};
        sq_op[k+1]         <= sq_op[k] << 2;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Prepare the division: the dominant component is root/2 rounded up, the
  // others divide (|n| << FRAC_BITS) + root by 2*root, which rounds to
  // nearest with ties away from zero.
  logic [RW:0]  root_inc;
  assign root_inc = {1'b0, sq_root[RW]} + (RW+1)'(1);

  logic          dv_vld   [0:ND];
  logic [1:0]    dv_dom   [0:ND];
  logic          dv_degen [0:ND];
  logic [3:0]    dv_neg   [0:ND];
  logic [RW-1:0] dv_qd    [0:ND];
  logic [DW-1:0] dv_div   [0:ND];
  logic [ND-1:0] dv_num   [0:ND][4];
  logic [DW-1:0] dv_rem   [0:ND][4];
  logic [ND-1:0] dv_quo   [0:ND][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_side[RW].vld;
    end
    if (en) begin
      dv_dom[0]   <= sq_side[RW].dom;
      dv_degen[0] <= sq_side[RW].degen;
      dv_neg[0]   <= sq_side[RW].neg;
      dv_qd[0]    <= root_inc[RW:1];
      dv_div[0]   <= {sq_root[RW], 1'b0};
      for (int i = 0; i < 4; i++) begin
        dv_num[0][i] <= (ND'(sq_side[RW].mag[i]) << FRAC_BITS) + ND'(sq_root[RW]);
        dv_rem[0][i] <= '0;
        dv_quo[0][i] <= '0;
      end
    end
  end

  // Restoring divider, one quotient bit per stage in each of four lanes.
  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [DW:0] r2   [4];
    logic        ge   [4];
    logic [DW:0] diff [4];
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        r2[i]   = {dv_rem[k][i], dv_num[k][i][ND-1]};
        ge[i]   = (r2[i] >= {1'b0, dv_div[k]});
        diff[i] = r2[i] - {1'b0, dv_div[k]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
      if (en) begin
        dv_dom[k+1]   <= dv_dom[k];
        dv_degen[k+1] <= dv_degen[k];
        dv_neg[k+1]   <= dv_neg[k];
        dv_qd[k+1]    <= dv_qd[k];
        dv_div[k+1]   <= dv_div[k];
        for (int i = 0; i < 4; i++) begin
          dv_num[k+1][i] <= dv_num[k][i] << 1;
          dv_rem[k+1][i] <= ge[i] ? diff[i][DW-1:0] : r2[i][DW-1:0];
          dv_quo[k+1][i] <= {dv_quo[k][i][ND-2:0], ge[i]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sign, clamp to [-1.0, +1.0] (zero when degenerate) and select the dominant lane.
  logic [ND-1:0]     lane_mag [4];
  logic              lane_neg [4];
  logic signed [15:0] lane_val [4];
  quat_t             res;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_dom[ND] == 2'(i)) begin
        lane_mag[i] = ND'(dv_qd[ND]);
        lane_neg[i] = 1'b0;
      end else begin
        lane_mag[i] = dv_quo[ND][i];
        lane_neg[i] = dv_neg[ND][i];
      end
      if (dv_degen[ND]) begin
        lane_val[i] = '0;
      end else if (lane_neg[i]) begin
        lane_val[i] = (lane_mag[i] > ND'(LOM)) ? -16'(LOM) : -16'(lane_mag[i]);
      end else begin
        lane_val[i] = (lane_mag[i] > ND'(HI)) ? 16'(HI) : 16'(lane_mag[i]);
      end
    end
    res.quat_w     = lane_val[DOM_W];
    res.quat_x     = lane_val[DOM_X];
    res.quat_y     = lane_val[DOM_Y];
    res.quat_z     = lane_val[DOM_Z];
    res.degenerate = dv_degen[ND];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (en) begin
      quat.valid <= dv_vld[ND];
    end
    if (en) begin
      quat.data <= res;
    end
  end

endmodule

[tb/sv/rmq_checker.sv]
// Checker for the rotation-matrix-to-quaternion block: predicts each quaternion
// from the accepted matrices and compares it field by field with the output.
// Depends on rmq_pkg and the stream interfaces in rmq_if.sv.
module rmq_checker
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst,
  rmq_mat_if.sink    mat_mon,
  rmq_quat_if.sink   quat_mon,
  output int         fail_count,
  output int         pending
);

  quat_t quat_queue[$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp_q(input longint v);
    longint one, hi, lo;
    one = longint'(1) << FRAC_BITS;
    hi = (one < 32767) ? one : 32767;
    lo = (-one > -32768) ? -one : -32768;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[15:0];
  endfunction

  function automatic longint scaled_ratio(input longint n, input longint unsigned root);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    q = ((mag << FRAC_BITS) + root) / (root * 2);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic quat_t matrix_to_quat(input mat_t m);
    longint one, tr, arg;
    longint n[4];
    logic [1:0] dom;
    longint unsigned root;
    quat_t r;
    logic signed [15:0] q[4];
    one = longint'(1) << FRAC_BITS;
    tr = longint'(m.m00) + longint'(m.m11) + longint'(m.m22);
    if (tr > 0) begin
      dom = DOM_W; arg = tr + one;
      n[1] = m.m21 - m.m12; n[2] = m.m02 - m.m20; n[3] = m.m10 - m.m01;
    end else if (m.m00 > m.m11 && m.m00 > m.m22) begin
      dom = DOM_X; arg = one + m.m00 - m.m11 - m.m22;
      n[0] = m.m21 - m.m12; n[2] = m.m01 + m.m10; n[3] = m.m02 + m.m20;
    end else if (m.m11 > m.m22) begin
      dom = DOM_Y; arg = one + m.m11 - m.m00 - m.m22;
      n[0] = m.m02 - m.m20; n[1] = m.m01 + m.m10; n[3] = m.m12 + m.m21;
    end else begin
      dom = DOM_Z; arg = one + m.m22 - m.m00 - m.m11;
      n[0] = m.m10 - m.m01; n[1] = m.m02 + m.m20; n[2] = m.m12 + m.m21;
    end
    n[dom] = 0;
    r = '0;
    if (arg <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    root = int_sqrt(longint'(arg) << FRAC_BITS);
    for (int i = 0; i < 4; i++) begin
      if (i == dom) q[i] = clamp_q(longint'((root + 1) >> 1));
      else q[i] = clamp_q(scaled_ratio(n[i], root));
    end
    r.quat_w = q[0]; r.quat_x = q[1]; r.quat_y = q[2]; r.quat_z = q[3];
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  assign pending = quat_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    quat_t want;
    quat_t got;
    if (!rst) begin
      if (mat_mon.valid && mat_mon.ready)
        quat_queue = {quat_queue, matrix_to_quat(mat_mon.data)};
      if (quat_mon.valid && quat_mon.ready) begin
        got = quat_mon.data;
        if (quat_queue.size() == 0) begin
          report_mismatch("unexpected quaternion", 1, 0);
        end else begin
          want = quat_queue.pop_front();
          if (got.quat_w !== want.quat_w) report_mismatch("quat_w", got.quat_w, want.quat_w);
          if (got.quat_x !== want.quat_x) report_mismatch("quat_x", got.quat_x, want.quat_x);
          if (got.quat_y !== want.quat_y) report_mismatch("quat_y", got.quat_y, want.quat_y);
          if (got.quat_z !== want.quat_z) report_mismatch("quat_z", got.quat_z, want.quat_z);
          if (got.degenerate !== want.degenerate)
            report_mismatch("degenerate", got.degenerate, want.degenerate);
        end
      end
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the rotation-matrix-to-quaternion block: drives matrices
// under several idling patterns and gives the verdict from the checker's count.
// Depends on rmq_pkg, rmq_if.sv, rmq_checker.sv and the block itself.
module tb_top
  import rmq_pkg::*;
();

  localparam int LATENCY = 60;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic signed [15:0] ONE = 16'sd16384;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off;

  rmq_mat_if  mat ();
  rmq_quat_if quat ();

  rotation_matrix_to_quaternion #(.FRAC_BITS(14)) u_top (
    .clk(clk), .rst(rst), .mat(mat.sink), .quat(quat.source)
  );

  rmq_checker #(.FRAC_BITS(14)) u_checker (
    .clk(clk), .rst(rst), .mat_mon(mat.sink), .quat_mon(quat.sink),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver works in its own process. A positive hold_off keeps ready
  // low regardless of the stall percentage while it counts down, so that the
  // pipeline fills and the block has to refuse input.
  initial begin
    quat.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        quat.ready <= 1'b0;
        hold_off = hold_off - 1;
      end else begin
        quat.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happened on either channel.
  always @(posedge clk) begin
    if (rst || (mat.valid && mat.ready) || (quat.valid && quat.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // A random entry: mostly inside the Q1.14 range, sometimes any 16-bit pattern
  // so that every bit of every field is toggled and the clamp is exercised.
  function automatic logic signed [15:0] random_entry();
    if ($urandom_range(9) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(32768)) - 16'sd16384);
  endfunction

  // A matrix near a rotation: mostly a diagonal of signs near +-1.0 with small noise,
  // so that each of the four branches is reached with realistic values, else small random entries.
  function automatic mat_t random_rotation();
    logic signed [15:0] e[9];
    int p;
    mat_t m;
    p = $urandom_range(5);
    for (int i = 0; i < 9; i++) e[i] = 16'($signed($urandom_range(4000)) - 16'sd2000);
    case (p)
      0: begin e[0] = 16'(ONE - $urandom_range(3000)); e[4] = 16'(ONE - $urandom_range(3000));
               e[8] = 16'(ONE - $urandom_range(3000)); end
      1: begin e[0] = 16'(ONE - $urandom_range(2000)); e[4] = 16'(-ONE + $urandom_range(2000));
               e[8] = 16'(-ONE + $urandom_range(2000)); end
      2: begin e[0] = 16'(-ONE + $urandom_range(2000)); e[4] = 16'(ONE - $urandom_range(2000));
               e[8] = 16'(-ONE + $urandom_range(2000)); end
      3: begin e[0] = 16'(-ONE + $urandom_range(2000)); e[4] = 16'(-ONE + $urandom_range(2000));
               e[8] = 16'(ONE - $urandom_range(2000)); end
      default: begin
        for (int i = 0; i < 9; i++)
          e[i] = 16'($signed($urandom_range(16000)) - 16'sd8000);
      end
    endcase
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // leaving valid high so that the next matrix can follow without a gap.
  task automatic send_matrix(input mat_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      mat.valid <= 1'b0;
      @(negedge clk);
    end
    mat.valid <= 1'b1;
    mat.data  <= m;
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_diag(input logic signed [15:0] a, b, c,
                           input logic signed [15:0] o);
    send_matrix({a, o, -o, -o, b, o, o, -o, c});
  endtask

  initial begin
    mat_t m;
    rst = 1'b1;
    mat.valid = 1'b0;
    mat.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: identity, each dominant branch, ties on the diagonal,
    // matrices that are not rotations and the extremes of the 16-bit range.
    send_diag(ONE, ONE, ONE, 16'sd0);
    send_diag(ONE, -ONE, -ONE, 16'sd0);
    send_diag(-ONE, ONE, -ONE, 16'sd0);
    send_diag(-ONE, -ONE, ONE, 16'sd0);
    send_diag(-ONE, -ONE, -ONE, 16'sd0);
    send_diag(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_diag(16'sd0, 16'sd0, 16'sd0, ONE);
    send_diag(-16'sd100, -16'sd100, -16'sd200, 16'sd500);
    send_diag(-16'sd100, -16'sd200, -16'sd200, 16'sd500);
    send_diag(-16'sd200, -16'sd100, -16'sd100, 16'sd500);
    send_diag(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_diag(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_diag(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767);
    send_diag(16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768);
    send_diag(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_diag(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768);
    send_diag(-ONE, -ONE, 16'sd1, 16'sd1);
    send_diag(16'sd1, -16'sd1, 16'sd0, -16'sd1);
    send_matrix({16'sd0, -ONE, 16'sd0, ONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ONE});
    send_matrix({-16'sd1, ONE, ONE, ONE, -16'sd1, ONE, ONE, ONE, -16'sd1});

    // Random part in phases of idling, with one long receiver hold-off.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 300; end
      endcase
      for (int i = 0; i < 206; i++) begin
        if ($urandom_range(3) == 0)
          m = {random_entry(), random_entry(), random_entry(), random_entry(),
               random_entry(), random_entry(), random_entry(), random_entry(),
               random_entry()};
        else
          m = random_rotation();
        send_matrix(m);
      end
    end
    mat.valid <= 1'b0;

    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
